// ===== src/rmh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared widths, constants, types and the rounding helper for the relaxed
// monotone Hermite evaluator.
// ----------------------------------------------------------------------------
package rmh_pkg;

   // Fraction bits of keys, position and results; the port widths below
   // are sized for this value.
   localparam int FRACTION_BITS = 16;

   // Port field widths.
   localparam int KEY_W   = 24;
   localparam int T_W     = 17;
   localparam int VAL_W   = 26;
   localparam int SLOPE_W = 32;

   // Internal widths.
   localparam int DIFF_W  = KEY_W + 1;          // signed key difference
   localparam int TAN_W   = DIFF_W + 1;         // signed tangent and pair sum
   localparam int COEF_W  = 32;                 // polynomial terms and partial sums
   localparam int PROD_W  = T_W + 1 + COEF_W;   // t times a polynomial term

   // Division by ten as a multiply by a scaled reciprocal.
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP10 = RECIP_W'(429496730);
   localparam int QPROD_W     = TAN_W + RECIP_W;
   localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;
   localparam logic [TAN_W-1:0] ROUND10 = TAN_W'(5);

   // Output range of the value.
   localparam int VAL_HI = (1 << (VAL_W - 1)) - 1;
   localparam int VAL_LO = -(1 << (VAL_W - 1));

   // Register stages per unit.
   localparam int TAN_LAT  = 4;
   localparam int EVAL_LAT = 6;
   localparam int PIPE_LAT = 3 + TAN_LAT + EVAL_LAT;

   typedef struct packed {
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] c3;
      logic signed [COEF_W-1:0] c3x3;
      logic [KEY_W-1:0]         key_start;
      logic [T_W-1:0]           t;
   } rmh_coef_type;

   // Divide by 2^sh, rounding to nearest with ties away from zero.
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] x,
      input int unsigned              sh
   );
      logic signed [PROD_W-1:0] bias;
      bias = (PROD_W'(1) << (sh - 1)) - PROD_W'(x[PROD_W-1]);
      return (x + bias) >>> sh;
   endfunction

endpackage
`default_nettype wire

// ===== src/rmh_tangent.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_tangent
// Four-stage tangent unit: from two neighboring differences it forms either
// a tenth of their sum or their clamped mean.
// ----------------------------------------------------------------------------
module rmh_tangent
   import rmh_pkg::*;
(
   input  wire  logic                     clock,
   input  wire  logic                     reset,
   input  wire  logic                     in_valid,
   input  wire  logic signed [DIFF_W-1:0] diff_a,
   input  wire  logic signed [DIFF_W-1:0] diff_b,
   output logic                           out_valid,
   output logic signed [TAN_W-1:0]        tangent_out
);

   // Stage 1: pair sum, magnitudes, case decision.
   logic                     v1_ff;
   logic signed [TAN_W-1:0]  sum_ff,    sum_in;
   logic                     split_ff,  split_in;
   logic                     neg_a_ff;
   logic [DIFF_W-1:0]        mag_a_ff,  mag_a_in;
   logic [DIFF_W-1:0]        mag_b_ff,  mag_b_in;

   // Stage 2: rounded numerator for the tenth, clamped mean, result sign.
   logic                     v2_ff;
   logic [TAN_W-1:0]         num_ff,    num_in;
   logic [DIFF_W-1:0]        agree_ff,  agree_in;
   logic                     sign2_ff,  sign2_in;
   logic                     split2_ff;
   logic [TAN_W-1:0]         sum_mag;
   logic [TAN_W-1:0]         pair_sum;
   logic [DIFF_W-1:0]        mean_mag;
   logic [DIFF_W-1:0]        min_mag;
   logic [DIFF_W+1:0]        limit_mag;

   // Stage 3: reciprocal product.
   logic                     v3_ff;
   logic [QPROD_W-1:0]       qprod_ff;
   logic [DIFF_W-1:0]        agree3_ff;
   logic                     sign3_ff;
   logic                     split3_ff;

   // Stage 4: signed tangent.
   logic                     v4_ff;
   logic signed [TAN_W-1:0]  tan_ff,    tan_in;
   logic [DIFF_W-1:0]        tan_mag;

   always_comb begin
      sum_in   = TAN_W'(diff_a) + TAN_W'(diff_b);
      // A zero difference counts as a sign disagreement.
      split_in = (diff_a == '0) || (diff_b == '0) ||
                 (diff_a[DIFF_W-1] != diff_b[DIFF_W-1]);
      mag_a_in = diff_a[DIFF_W-1] ? DIFF_W'(-diff_a) : DIFF_W'(diff_a);
      mag_b_in = diff_b[DIFF_W-1] ? DIFF_W'(-diff_b) : DIFF_W'(diff_b);
   end

   always_comb begin
      sum_mag   = sum_ff[TAN_W-1] ? TAN_W'(-sum_ff) : TAN_W'(sum_ff);
      num_in    = sum_mag + ROUND10;
      pair_sum  = TAN_W'(mag_a_ff) + TAN_W'(mag_b_ff) + TAN_W'(1);
      mean_mag  = pair_sum[TAN_W-1:1];
      min_mag   = (mag_a_ff < mag_b_ff) ? mag_a_ff : mag_b_ff;
      limit_mag = {min_mag, 2'b00};
      agree_in  = ((DIFF_W+2)'(mean_mag) < limit_mag) ? mean_mag : DIFF_W'(limit_mag);
      sign2_in  = split_ff ? sum_ff[TAN_W-1] : neg_a_ff;
   end

   always_comb begin
      tan_mag = split3_ff ? DIFF_W'(qprod_ff[QPROD_W-1:RECIP_SHIFT]) : agree3_ff;
      tan_in  = sign3_ff ? -TAN_W'(tan_mag) : TAN_W'(tan_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      split_ff  <= split_in;
      neg_a_ff  <= diff_a[DIFF_W-1];
      mag_a_ff  <= mag_a_in;
      mag_b_ff  <= mag_b_in;

      num_ff    <= num_in;
      agree_ff  <= agree_in;
      sign2_ff  <= sign2_in;
      split2_ff <= split_ff;

      qprod_ff  <= QPROD_W'(num_ff) * QPROD_W'(RECIP10);
      agree3_ff <= agree_ff;
      sign3_ff  <= sign2_ff;
      split3_ff <= split2_ff;

      tan_ff    <= tan_in;
   end

   assign out_valid   = v4_ff;
   assign tangent_out = tan_ff;

`ifndef SYNTH
   // A nonzero tangent carries the sign of the pair sum.
   a_tan_sign: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && (tan_ff != '0)) |-> (tan_ff[TAN_W-1] == $past(sum_ff[TAN_W-1], 3)))
      else $error("tangent sign differs from the sign of the difference sum");

   // Both rules keep the tangent within one key range.
   a_tan_range: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> ((tan_ff <= TAN_W'(1 << KEY_W)) && (tan_ff >= -TAN_W'(1 << KEY_W))))
      else $error("tangent magnitude out of range");
`endif

endmodule
`default_nettype wire

// ===== src/rmh_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_eval
// Six-stage Horner evaluation of the Hermite cubic and its derivative,
// alternating multiply stages with round-and-add stages, then saturation.
// ----------------------------------------------------------------------------
module rmh_eval
   import rmh_pkg::*;
(
   input  wire  logic                      clock,
   input  wire  logic                      reset,
   input  wire  logic                      in_valid,
   input  wire  rmh_coef_type              coef,
   output logic                            out_valid,
   output logic signed [VAL_W-1:0]         value_out,
   output logic signed [SLOPE_W-1:0]       slope_out
);

   logic [EVAL_LAT-1:0] valid_ff;

   // Stage 1: t * c3 and t * 3c3.
   logic signed [T_W:0]        t_in_s;
   logic signed [PROD_W-1:0]   pv1_ff, ps1_ff;
   logic signed [COEF_W-1:0]   e1_c1_ff, e1_c2_ff;
   logic [KEY_W-1:0]           e1_key_ff;
   logic [T_W-1:0]             e1_t_ff;

   // Stage 2: inner Horner sums.
   logic signed [COEF_W-1:0]   acc1_ff, acc1_in;
   logic signed [COEF_W-1:0]   accs_ff, accs_in;
   logic signed [COEF_W-1:0]   e2_c1_ff;
   logic [KEY_W-1:0]           e2_key_ff;
   logic [T_W-1:0]             e2_t_ff;

   // Stage 3: second products.
   logic signed [T_W:0]        t2_s;
   logic signed [PROD_W-1:0]   pv2_ff, ps2_ff;
   logic signed [COEF_W-1:0]   e3_c1_ff;
   logic [KEY_W-1:0]           e3_key_ff;
   logic [T_W-1:0]             e3_t_ff;

   // Stage 4: value accumulator and unsaturated slope.
   logic signed [COEF_W-1:0]   acc2_ff, acc2_in;
   logic signed [SLOPE_W:0]    slope4_ff, slope4_in;
   logic [KEY_W-1:0]           e4_key_ff;
   logic [T_W-1:0]             e4_t_ff;

   // Stage 5: last value product.
   logic signed [T_W:0]        t4_s;
   logic signed [PROD_W-1:0]   pv3_ff;
   logic signed [SLOPE_W:0]    slope5_ff;
   logic [KEY_W-1:0]           e5_key_ff;

   // Stage 6: final sum and saturation.
   logic signed [COEF_W-1:0]   val_sum;
   logic signed [VAL_W-1:0]    val_ff,   val_in;
   logic signed [SLOPE_W-1:0]  slope_ff, slope_in;

   always_comb begin
      t_in_s  = signed'({1'b0, coef.t});
      t2_s    = signed'({1'b0, e2_t_ff});
      t4_s    = signed'({1'b0, e4_t_ff});

      acc1_in = e1_c2_ff + COEF_W'(round_shift(pv1_ff, FRACTION_BITS));
      accs_in = (e1_c2_ff <<< 1) + COEF_W'(round_shift(ps1_ff, FRACTION_BITS));

      acc2_in   = e3_c1_ff + COEF_W'(round_shift(pv2_ff, FRACTION_BITS));
      slope4_in = (SLOPE_W+1)'(e3_c1_ff) +
                  (SLOPE_W+1)'(round_shift(ps2_ff, FRACTION_BITS));
   end

   always_comb begin
      val_sum = COEF_W'(e5_key_ff) + COEF_W'(round_shift(pv3_ff, FRACTION_BITS));
      if (val_sum > COEF_W'(VAL_HI)) begin
         val_in = VAL_W'(VAL_HI);
      end else if (val_sum < COEF_W'(VAL_LO)) begin
         val_in = VAL_W'(VAL_LO);
      end else begin
         val_in = VAL_W'(val_sum);
      end

      // The slope overflows only when the guard bit and the sign bit differ.
      if (slope5_ff[SLOPE_W] != slope5_ff[SLOPE_W-1]) begin
         slope_in = {slope5_ff[SLOPE_W], {(SLOPE_W-1){~slope5_ff[SLOPE_W]}}};
      end else begin
         slope_in = SLOPE_W'(slope5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[EVAL_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      pv1_ff    <= t_in_s * coef.c3;
      ps1_ff    <= t_in_s * coef.c3x3;
      e1_c1_ff  <= coef.c1;
      e1_c2_ff  <= coef.c2;
      e1_key_ff <= coef.key_start;
      e1_t_ff   <= coef.t;

      acc1_ff   <= acc1_in;
      accs_ff   <= accs_in;
      e2_c1_ff  <= e1_c1_ff;
      e2_key_ff <= e1_key_ff;
      e2_t_ff   <= e1_t_ff;

      pv2_ff    <= t2_s * acc1_ff;
      ps2_ff    <= t2_s * accs_ff;
      e3_c1_ff  <= e2_c1_ff;
      e3_key_ff <= e2_key_ff;
      e3_t_ff   <= e2_t_ff;

      acc2_ff   <= acc2_in;
      slope4_ff <= slope4_in;
      e4_key_ff <= e3_key_ff;
      e4_t_ff   <= e3_t_ff;

      pv3_ff    <= t4_s * acc2_ff;
      slope5_ff <= slope4_ff;
      e5_key_ff <= e4_key_ff;

      val_ff    <= val_in;
      slope_ff  <= slope_in;
   end

   assign out_valid = valid_ff[EVAL_LAT-1];
   assign value_out = val_ff;
   assign slope_out = slope_ff;

`ifndef SYNTH
   // Every result stems from a matching coefficient beat.
   a_eval_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, EVAL_LAT))
      else $error("evaluation result without matching coefficient beat");
`endif

endmodule
`default_nettype wire

// ===== src/relaxed_monotone_hermite_scalar.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// relaxed_monotone_hermite_scalar
// Monotone-leaning cubic Hermite evaluation of one scalar segment: tangents
// from four keys, then the interpolated value and its derivative in t.
// Usage:
//   A request beat is taken at a rising edge where start is high and busy is
//   low. It carries four keys (unsigned Q8.16) and local_t (unsigned Q1.16, values
//   above 1.0 are treated as 1.0).
//   The result beat is driven on rsp_value_out and rsp_slope_out with
//   rsp_valid high for one cycle. There is no backpressure.
//   Throughput is one beat per cycle: every unit is a straight pipeline
//   (2 input stages, 4 tangent stages, 1 coefficient stage, 6 evaluation
//   stages), so a new request may follow in every cycle.
//   Latency is set by the tangent unit's reciprocal divide and the three
//   dependent multiply-round steps of the Horner evaluation.
//   busy is high from the first reset edge until the first edge after reset
//   is released. Reset clears all valid bits, so beats in flight are dropped.
// ----------------------------------------------------------------------------
module relaxed_monotone_hermite_scalar
   import rmh_pkg::*;
(
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic                    start,
   output logic                          busy,
   input  wire  logic [KEY_W-1:0]        req_key_before,
   input  wire  logic [KEY_W-1:0]        req_key_start,
   input  wire  logic [KEY_W-1:0]        req_key_end,
   input  wire  logic [KEY_W-1:0]        req_key_after,
   input  wire  logic [T_W-1:0]          req_local_t,
   output logic                          rsp_valid,
   output logic signed [VAL_W-1:0]       rsp_value_out,
   output logic signed [SLOPE_W-1:0]     rsp_slope_out
);

   localparam int unsigned ONE = 1 << FRACTION_BITS;

   logic busy_ff;

   // Stage 0: input capture with t clamped to one.
   logic               s0_valid_ff;
   logic [KEY_W-1:0]   s0_k0_ff, s0_k1_ff, s0_k2_ff, s0_k3_ff;
   logic [T_W-1:0]     s0_t_ff, s0_t_in;

   // Stage 1: key differences.
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s1_before_ff, s1_mid_ff, s1_after_ff;
   logic [KEY_W-1:0]         s1_k1_ff;
   logic [T_W-1:0]           s1_t_ff;

   // Side data waiting for the tangent unit.
   logic signed [DIFF_W-1:0] mid_dly_ff [TAN_LAT];
   logic [KEY_W-1:0]         key_dly_ff [TAN_LAT];
   logic [T_W-1:0]           t_dly_ff   [TAN_LAT];

   logic                     tan0_valid, tan1_valid;
   logic signed [TAN_W-1:0]  tan0, tan1;

   // Coefficient stage.
   logic                     coef_valid_ff;
   rmh_coef_type             coef_ff, coef_in;
   logic signed [COEF_W-1:0] d_x, m0_x, m1_x;

   always_comb begin
      if (32'(req_local_t) > ONE) begin
         s0_t_in = T_W'(ONE);
      end else begin
         s0_t_in = req_local_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         coef_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         s0_valid_ff   <= start && !busy_ff;
         s1_valid_ff   <= s0_valid_ff;
         coef_valid_ff <= tan0_valid && tan1_valid;
      end
   end

   always_ff @(posedge clock) begin
      s0_k0_ff     <= req_key_before;
      s0_k1_ff     <= req_key_start;
      s0_k2_ff     <= req_key_end;
      s0_k3_ff     <= req_key_after;
      s0_t_ff      <= s0_t_in;

      s1_before_ff <= DIFF_W'(s0_k1_ff) - DIFF_W'(s0_k0_ff);
      s1_mid_ff    <= DIFF_W'(s0_k2_ff) - DIFF_W'(s0_k1_ff);
      s1_after_ff  <= DIFF_W'(s0_k3_ff) - DIFF_W'(s0_k2_ff);
      s1_k1_ff     <= s0_k1_ff;
      s1_t_ff      <= s0_t_ff;

      mid_dly_ff[0] <= s1_mid_ff;
      key_dly_ff[0] <= s1_k1_ff;
      t_dly_ff[0]   <= s1_t_ff;
      for (int i = 1; i < TAN_LAT; i++) begin
         mid_dly_ff[i] <= mid_dly_ff[i-1];
         key_dly_ff[i] <= key_dly_ff[i-1];
         t_dly_ff[i]   <= t_dly_ff[i-1];
      end

      coef_ff <= coef_in;
   end

   rmh_tangent u_tan_start (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .diff_a      (s1_before_ff),
      .diff_b      (s1_mid_ff),
      .out_valid   (tan0_valid),
      .tangent_out (tan0)
   );

   rmh_tangent u_tan_end (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .diff_a      (s1_mid_ff),
      .diff_b      (s1_after_ff),
      .out_valid   (tan1_valid),
      .tangent_out (tan1)
   );

   // c1 = m0, c2 = 3D - 2m0 - m1, c3 = m0 + m1 - 2D.
   always_comb begin
      d_x  = COEF_W'(mid_dly_ff[TAN_LAT-1]);
      m0_x = COEF_W'(tan0);
      m1_x = COEF_W'(tan1);
      coef_in.c1        = m0_x;
      coef_in.c2        = (d_x <<< 1) + d_x - (m0_x <<< 1) - m1_x;
      coef_in.c3        = m0_x + m1_x - (d_x <<< 1);
      coef_in.c3x3      = (m0_x <<< 1) + m0_x + (m1_x <<< 1) + m1_x
                          - (d_x <<< 2) - (d_x <<< 1);
      coef_in.key_start = key_dly_ff[TAN_LAT-1];
      coef_in.t         = t_dly_ff[TAN_LAT-1];
   end

   rmh_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (coef_valid_ff),
      .coef      (coef_ff),
      .out_valid (rsp_valid),
      .value_out (rsp_value_out),
      .slope_out (rsp_slope_out)
   );

   assign busy = busy_ff;

`ifndef SYNTH
   // Each result beat stems from an accepted request beat.
   a_top_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("result beat without matching request beat");

   // Both tangent units run in lockstep.
   a_tan_lockstep: assert property (@(posedge clock) disable iff (reset)
      tan0_valid == tan1_valid)
      else $error("tangent units out of step");

   // The captured position never exceeds one.
   a_t_clamped: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff |-> (32'(s0_t_ff) <= ONE))
      else $error("local t above one after clamping");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_relaxed_monotone_hermite_scalar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relaxed_monotone_hermite_scalar
// Drives segments of four keys and a position into the Hermite evaluator,
// predicts each interpolated value and slope in 64-bit integer arithmetic,
// and checks every result beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb_relaxed_monotone_hermite_scalar
   import rmh_pkg::*;
();

   localparam int      FB         = FRACTION_BITS;
   localparam int      ONE        = 1 << FB;
   localparam longint  HALF_LSB   = longint'(1) << (FB - 1);
   localparam int      KEY_MAX    = (1 << KEY_W) - 1;
   localparam int      T_MAX      = (1 << T_W) - 1;
   localparam longint  SLOPE_TOP  = 64'sd2147483647;
   localparam longint  SLOPE_BOT  = -64'sd2147483648;
   localparam int      RANDOM_SEGMENTS = 750;

   typedef struct {
      logic [KEY_W-1:0] key_before;
      logic [KEY_W-1:0] key_start;
      logic [KEY_W-1:0] key_end;
      logic [KEY_W-1:0] key_after;
      logic [T_W-1:0]   local_t;
      bit               hold;     // wait for all results before sending
   } segment_type;

   typedef struct {
      int unsigned                index;
      logic signed [VAL_W-1:0]    value;
      logic signed [SLOPE_W-1:0]  slope;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KEY_W-1:0] req_key_before = '0;
   logic [KEY_W-1:0] req_key_start  = '0;
   logic [KEY_W-1:0] req_key_end    = '0;
   logic [KEY_W-1:0] req_key_after  = '0;
   logic [T_W-1:0]   req_local_t    = '0;
   logic                       rsp_valid;
   logic signed [VAL_W-1:0]    rsp_value_out;
   logic signed [SLOPE_W-1:0]  rsp_slope_out;

   segment_type segments_todo[$];
   point_type   points_due[$];
   segment_type on_bus;
   int unsigned segments_sent = 0;
   int unsigned points_seen = 0;
   int unsigned error_count = 0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 1;

   relaxed_monotone_hermite_scalar u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_key_before (req_key_before),
      .req_key_start  (req_key_start),
      .req_key_end    (req_key_end),
      .req_key_after  (req_key_after),
      .req_local_t    (req_local_t),
      .rsp_valid      (rsp_valid),
      .rsp_value_out  (rsp_value_out),
      .rsp_slope_out  (rsp_slope_out)
   );

   always #10 clock = ~clock;

   // Divide by 2^FB, rounding half away from zero.
   function automatic longint scale_down(longint x);
      if (x >= 0) return (x + HALF_LSB) >>> FB;
      return -((-x + HALF_LSB) >>> FB);
   endfunction

   function automatic longint end_tangent(longint a, longint b);
      longint sum, ma, mb, m, lim;
      sum = a + b;
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      // A flat side or a change of direction gives the damped sum.
      if (a == 0 || b == 0 || ((a < 0) != (b < 0))) begin
         m = (((sum < 0) ? -sum : sum) + 5) / 10;
         return (sum < 0) ? -m : m;
      end
      m   = (ma + mb + 1) >>> 1;
      lim = 4 * ((ma < mb) ? ma : mb);
      if (lim < m) m = lim;
      return (a < 0) ? -m : m;
   endfunction

   function automatic point_type predict_point(segment_type s, int unsigned index);
      longint k0, k1, k2, k3, t, span, m0, m1, c1, c2, c3, acc, val, slope;
      point_type p;
      k0 = longint'(s.key_before);
      k1 = longint'(s.key_start);
      k2 = longint'(s.key_end);
      k3 = longint'(s.key_after);
      t  = longint'(s.local_t);
      if (t > longint'(ONE)) t = longint'(ONE);
      span = k2 - k1;
      m0 = end_tangent(k1 - k0, span);
      m1 = end_tangent(span, k3 - k2);
      c1 = m0;
      c2 = 3 * span - 2 * m0 - m1;
      c3 = m0 + m1 - 2 * span;
      acc = c2 + scale_down(t * c3);
      acc = c1 + scale_down(t * acc);
      val = k1 + scale_down(t * acc);
      acc = 2 * c2 + scale_down(t * (3 * c3));
      slope = c1 + scale_down(t * acc);
      if (val > longint'(VAL_HI)) val = VAL_HI;
      if (val < longint'(VAL_LO)) val = VAL_LO;
      if (slope > SLOPE_TOP) slope = SLOPE_TOP;
      if (slope < SLOPE_BOT) slope = SLOPE_BOT;
      p.index = index;
      p.value = val[VAL_W-1:0];
      p.slope = slope[SLOPE_W-1:0];
      return p;
   endfunction

   task automatic add_segment(int unsigned k0, int unsigned k1, int unsigned k2,
                              int unsigned k3, int unsigned t, bit hold);
      segment_type s;
      s.key_before = k0[KEY_W-1:0];
      s.key_start  = k1[KEY_W-1:0];
      s.key_end    = k2[KEY_W-1:0];
      s.key_after  = k3[KEY_W-1:0];
      s.local_t    = t[T_W-1:0];
      s.hold       = hold;
      segments_todo.insert(segments_todo.size(), s);
   endtask

   function automatic int unsigned random_step(int unsigned widest);
      int unsigned scale;
      scale = $urandom_range(0, widest);
      if (scale == 0) return $urandom_range(0, 15);
      if (scale == 1) return $urandom_range(0, 4095);
      if (scale == 2) return $urandom_range(0, 1 << 18);
      return $urandom_range(0, 1 << 22);
   endfunction

   task automatic add_random_segment(bit hold);
      int unsigned shape, pick, s0, s1, s2, base, t;
      int k0, k1, k2, k3;
      shape = $urandom_range(0, 99);
      pick  = $urandom_range(0, 9);
      if (pick == 0) t = 0;
      else if (pick == 1) t = ONE;
      else if (pick == 2) t = $urandom_range(ONE + 1, T_MAX);
      else t = $urandom_range(0, ONE);
      if (shape < 60) begin
         // Monotone run, rising or falling, steps of mixed magnitude.
         s0 = random_step(3);
         s1 = random_step(3);
         s2 = random_step(3);
         base = $urandom_range(0, KEY_MAX - (s0 + s1 + s2));
         if ($urandom_range(0, 1) == 0)
            add_segment(base, base + s0, base + s0 + s1, base + s0 + s1 + s2, t, hold);
         else
            add_segment(base + s0 + s1 + s2, base + s1 + s2, base + s2, base, t, hold);
      end else if (shape < 80) begin
         // Steps of random direction around a central key, some of them flat.
         s0 = random_step(2);
         s1 = random_step(2);
         s2 = random_step(2);
         pick = $urandom_range(0, 5);
         if (pick == 0) s0 = 0;
         else if (pick == 1) s1 = 0;
         else if (pick == 2) s2 = 0;
         k1 = $urandom_range(1 << 19, KEY_MAX - (1 << 19));
         k0 = ($urandom_range(0, 1) == 0) ? k1 - int'(s0) : k1 + int'(s0);
         k2 = ($urandom_range(0, 1) == 0) ? k1 - int'(s1) : k1 + int'(s1);
         k3 = ($urandom_range(0, 1) == 0) ? k2 - int'(s2) : k2 + int'(s2);
         add_segment(k0, k1, k2, k3, t, hold);
      end else begin
         add_segment($urandom_range(0, KEY_MAX), $urandom_range(0, KEY_MAX),
                     $urandom_range(0, KEY_MAX), $urandom_range(0, KEY_MAX), t, hold);
      end
   endtask

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   task automatic pick_next_burst();
      int unsigned r;
      r = $urandom_range(0, 3);
      if (r == 0) gap_left = 0;
      else if (r == 3) gap_left = $urandom_range(5, 20);
      else gap_left = $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
   endtask

   // Driver: one segment per beat, sent in bursts with random gaps.
   always @(posedge clock) begin
      logic send;
      send = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            points_due.insert(points_due.size(), predict_point(on_bus, segments_sent));
            segments_sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (segments_todo.size() != 0 &&
                      !(segments_todo[0].hold && points_seen != segments_sent)) begin
            on_bus = segments_todo.pop_front();
            req_key_before <= on_bus.key_before;
            req_key_start  <= on_bus.key_start;
            req_key_end    <= on_bus.key_end;
            req_key_after  <= on_bus.key_after;
            req_local_t    <= on_bus.local_t;
            send = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               pick_next_burst();
            end
         end
         start <= send;
      end
   end

   // Monitor: every result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid) begin
         points_seen <= points_seen + 1;
         if (points_due.size() == 0) begin
            flag_error($sformatf("result with none expected: value %0d slope %0d",
                                 rsp_value_out, rsp_slope_out));
         end else begin
            want = points_due.pop_front();
            if (rsp_value_out !== want.value || rsp_slope_out !== want.slope)
               flag_error($sformatf("segment %0d: value %0d (exp %0d) slope %0d (exp %0d)",
                                    want.index, rsp_value_out, want.value,
                                    rsp_slope_out, want.slope));
         end
      end
   end

   initial begin
      int unsigned i;
      // Directed segments: extremes, flat sides, direction changes, clamping.
      add_segment(0, 0, 0, 0, 0, 0);
      add_segment(KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, ONE, 0);
      add_segment(0, KEY_MAX, 0, KEY_MAX, ONE / 2, 0);
      add_segment(KEY_MAX, 0, KEY_MAX, 0, ONE / 2, 0);
      add_segment(0, 100, 200, 300, ONE / 3, 0);
      add_segment(0, 1, 24'h800001, KEY_MAX, ONE / 2, 0);
      add_segment(KEY_MAX, KEY_MAX - 1, 24'h100, 0, ONE / 4, 0);
      add_segment(0, KEY_MAX - 1, KEY_MAX, KEY_MAX, 3 * ONE / 4, 0);
      add_segment(5, 5, 1000, 2000, ONE / 2, 0);
      add_segment(100, 200, 300, 300, ONE / 2, 1);
      add_segment(100, 500, 500, 900, ONE / 2, 0);
      add_segment(KEY_MAX, 0, 0, KEY_MAX, ONE / 2, 0);
      add_segment(0, KEY_MAX, KEY_MAX, 0, ONE / 2, 0);
      add_segment(10, 20, 30, 40, T_MAX, 0);
      add_segment(40, 30, 20, 10, ONE + 1, 0);
      add_segment(0, 1, 2, 3, 1, 0);
      add_segment(3, 2, 1, 0, ONE - 1, 0);
      add_segment(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 17'h15555, 0);
      add_segment(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 17'h0AAAA, 0);
      add_segment(0, 24'h400000, 24'h800000, 24'hC00000, ONE / 2, 0);
      add_random_segment(1);
      for (i = 1; i < RANDOM_SEGMENTS; i++)
         add_random_segment($urandom_range(0, 99) == 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (segments_todo.size() != 0 || start) @(posedge clock);
      for (i = 0; i < 200 && points_seen != segments_sent; i++) @(posedge clock);
      repeat (30) @(posedge clock);
      if (points_due.size() != 0)
         flag_error($sformatf("%0d results never arrived", points_due.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: %0d segments sent, %0d results seen", segments_sent, points_seen);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
